// ===== rtl/hse_pkg.sv =====
// Shared types and constants for the heap sort engine.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package hse_pkg;

   localparam int HSE_CAPACITY   = 64;
   localparam int HSE_DATA_W     = 32;
   localparam int HSE_ADDR_W_MAX = 6;

   typedef struct packed {
      logic                      wr_en;
      logic [HSE_ADDR_W_MAX-1:0] wr_addr;
      logic [HSE_DATA_W-1:0]     wr_data;
      logic                      rd_en;
      logic [HSE_ADDR_W_MAX-1:0] rd_addr_a;
      logic [HSE_ADDR_W_MAX-1:0] rd_addr_b;
   } hse_mem_req_type;

endpackage

`default_nettype wire

// ===== rtl/hse_mem.sv =====
// Heap store: one write port and two registered read ports.
// Depends on hse_pkg for the request struct and data width.
`default_nettype none

module hse_mem #(
   parameter int DEPTH = hse_pkg::HSE_CAPACITY,
   parameter int AW    = hse_pkg::HSE_ADDR_W_MAX
) (
   input  wire logic                            clock,
   input  wire hse_pkg::hse_mem_req_type        mem_req,
   output logic [hse_pkg::HSE_DATA_W-1:0]       rd_data_a,
   output logic [hse_pkg::HSE_DATA_W-1:0]       rd_data_b
);
   import hse_pkg::*;

   logic [HSE_DATA_W-1:0] store_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_a <= store_mem[mem_req.rd_addr_a[AW-1:0]];
         rd_data_b <= store_mem[mem_req.rd_addr_b[AW-1:0]];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/hse_cmp.sv =====
// Shared compare unit: picks the larger child and tests it against the sifted value.
// Depends on hse_pkg for the data width.
`default_nettype none

module hse_cmp (
   input  wire logic signed [hse_pkg::HSE_DATA_W-1:0] hold_value,
   input  wire logic signed [hse_pkg::HSE_DATA_W-1:0] left_value,
   input  wire logic signed [hse_pkg::HSE_DATA_W-1:0] right_value,
   input  wire logic                                  right_ok,
   output logic                                       pick_right,
   output logic                                       child_wins,
   output logic signed [hse_pkg::HSE_DATA_W-1:0]      child_value
);
   import hse_pkg::*;

   always_comb begin
      pick_right  = right_ok && (right_value > left_value);
      child_value = pick_right ? right_value : left_value;
      child_wins  = child_value > hold_value;
   end

endmodule

`default_nettype wire

// ===== rtl/heap_sort_engine_top.sv =====
// Loading accepts one transaction per cycle. After the last element the engine builds
// the heap and sorts; each sift has two setup states (fetch and load, or read and swap),
// then a store read and a compare-and-write per level, one sift at a time through the
// single compare unit and the two read ports of the heap store. Each result is read,
// then offered until taken. No new set is taken until the last result leaves.
// Synchronous reset clears the count, the dropped flag and the FSM.
`default_nettype none

module heap_sort_engine_top #(
   parameter int CAPACITY = hse_pkg::HSE_CAPACITY
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [hse_pkg::HSE_DATA_W-1:0]   req_tdata,   // [31:0] value
   input  wire logic                             req_tlast,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [hse_pkg::HSE_DATA_W-1:0]        rsp_tdata,   // [31:0] sorted_value
   output logic                                  rsp_tlast,
   output logic                                  rsp_tuser    // [0] overflow
);
   import hse_pkg::*;

   localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int CHW = AW + 2;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_PREP   = 11'b000_0000_0010,
      ST_BFETCH = 11'b000_0000_0100,
      ST_BLOAD  = 11'b000_0000_1000,
      ST_SREAD  = 11'b000_0001_0000,
      ST_SCMP   = 11'b000_0010_0000,
      ST_SORT   = 11'b000_0100_0000,
      ST_XREAD  = 11'b000_1000_0000,
      ST_XSWAP  = 11'b001_0000_0000,
      ST_EREAD  = 11'b010_0000_0000,
      ST_EOUT   = 11'b100_0000_0000
   } state_type;

   state_type                    state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic                         dropped_ff, dropped_in;
   logic                         sort_ff, sort_in;
   logic [CW-1:0]                kidx_ff, kidx_in;
   logic [CW-1:0]                size_ff, size_in;
   logic [AW-1:0]                node_ff, node_in;
   logic [AW-1:0]                emit_ff, emit_in;
   logic signed [HSE_DATA_W-1:0] hold_ff, hold_in;

   hse_mem_req_type              mem_req;
   logic [HSE_DATA_W-1:0]        rd_data_a, rd_data_b;

   logic [CHW-1:0]               l_idx, r_idx;
   logic                         l_ok, r_ok;
   logic                         pick_right, child_wins;
   logic signed [HSE_DATA_W-1:0] child_value;
   logic [CW-1:0]                kidx_dec;
   logic                         last_emit, accept, room, sift_done;

   hse_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock     (clock),
      .mem_req   (mem_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   hse_cmp u_cmp (
      .hold_value  (hold_ff),
      .left_value  (rd_data_a),
      .right_value (rd_data_b),
      .right_ok    (r_ok),
      .pick_right  (pick_right),
      .child_wins  (child_wins),
      .child_value (child_value)
   );

   assign l_idx     = CHW'({node_ff, 1'b1});
   assign r_idx     = l_idx + CHW'(1);
   assign l_ok      = l_idx < CHW'(size_ff);
   assign r_ok      = r_idx < CHW'(size_ff);
   assign kidx_dec  = kidx_ff - CW'(1);
   assign last_emit = (CW'(emit_ff) + CW'(1)) == count_ff;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept    = req_tvalid && req_tready;
   assign room      = count_ff < CW'(CAPACITY);

   assign rsp_tvalid = (state_ff == ST_EOUT);
   assign rsp_tdata  = rd_data_a;
   assign rsp_tlast  = last_emit;
   assign rsp_tuser  = dropped_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      sort_in    = sort_ff;
      kidx_in    = kidx_ff;
      size_in    = size_ff;
      node_in    = node_ff;
      emit_in    = emit_ff;
      hold_in    = hold_ff;
      mem_req    = '0;
      sift_done  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (room) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = HSE_ADDR_W_MAX'(count_ff[AW-1:0]);
                  mem_req.wr_data = req_tdata;
                  count_in        = count_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            sort_in = 1'b0;
            if ((count_ff >> 1) == CW'(0)) begin
               state_in = ST_SORT;
            end else begin
               kidx_in  = count_ff >> 1;
               state_in = ST_BFETCH;
            end
         end
         ST_BFETCH: begin
            mem_req.rd_en     = 1'b1;
            mem_req.rd_addr_a = HSE_ADDR_W_MAX'(kidx_dec[AW-1:0]);
            node_in           = kidx_dec[AW-1:0];
            state_in          = ST_BLOAD;
         end
         ST_BLOAD: begin
            hold_in  = rd_data_a;
            size_in  = count_ff;
            state_in = ST_SREAD;
         end
         ST_SREAD: begin
            if (l_ok) begin
               mem_req.rd_en     = 1'b1;
               mem_req.rd_addr_a = HSE_ADDR_W_MAX'(l_idx[AW-1:0]);
               mem_req.rd_addr_b = HSE_ADDR_W_MAX'(r_idx[AW-1:0]);
               state_in          = ST_SCMP;
            end else begin
               sift_done = 1'b1;
            end
         end
         ST_SCMP: begin
            if (child_wins) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = HSE_ADDR_W_MAX'(node_ff);
               mem_req.wr_data = child_value;
               node_in         = pick_right ? r_idx[AW-1:0] : l_idx[AW-1:0];
               state_in        = ST_SREAD;
            end else begin
               sift_done = 1'b1;
            end
         end
         ST_SORT: begin
            sort_in = 1'b1;
            kidx_in = count_ff;
            if (count_ff > CW'(1)) begin
               state_in = ST_XREAD;
            end else begin
               emit_in  = '0;
               state_in = ST_EREAD;
            end
         end
         ST_XREAD: begin
            mem_req.rd_en     = 1'b1;
            mem_req.rd_addr_a = '0;
            mem_req.rd_addr_b = HSE_ADDR_W_MAX'(kidx_dec[AW-1:0]);
            state_in          = ST_XSWAP;
         end
         ST_XSWAP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = HSE_ADDR_W_MAX'(kidx_dec[AW-1:0]);
            mem_req.wr_data = rd_data_a;
            hold_in         = rd_data_b;
            node_in         = '0;
            size_in         = kidx_dec;
            state_in        = ST_SREAD;
         end
         ST_EREAD: begin
            mem_req.rd_en     = 1'b1;
            mem_req.rd_addr_a = HSE_ADDR_W_MAX'(emit_ff);
            state_in          = ST_EOUT;
         end
         ST_EOUT: begin
            if (rsp_tready) begin
               if (last_emit) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_IDLE;
               end else begin
                  emit_in  = emit_ff + AW'(1);
                  state_in = ST_EREAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The sifted value settles at its final node, then the outer loop advances.
      if (sift_done) begin
         mem_req.wr_en   = 1'b1;
         mem_req.wr_addr = HSE_ADDR_W_MAX'(node_ff);
         mem_req.wr_data = hold_ff;
         if (sort_ff) begin
            kidx_in = kidx_dec;
            if (kidx_dec > CW'(1)) begin
               state_in = ST_XREAD;
            end else begin
               emit_in  = '0;
               state_in = ST_EREAD;
            end
         end else if (kidx_ff == CW'(1)) begin
            state_in = ST_SORT;
         end else begin
            kidx_in  = kidx_dec;
            state_in = ST_BFETCH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         sort_ff    <= 1'b0;
         kidx_ff    <= '0;
         size_ff    <= '0;
         node_ff    <= '0;
         emit_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         sort_ff    <= sort_in;
         kidx_ff    <= kidx_in;
         size_ff    <= size_in;
         node_ff    <= node_in;
         emit_ff    <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

endmodule

`default_nettype wire

// ===== rtl/hse_checker.sv =====
// Port-level checks for the heap sort engine, bound to the top level.
// Depends on hse_pkg for the data width and on heap_sort_engine_top for the bind.
`default_nettype none

module hse_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           req_tlast,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [hse_pkg::HSE_DATA_W-1:0] rsp_tdata,
   input wire logic                           rsp_tlast,
   input wire logic                           rsp_tuser
);
   import hse_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result transaction offered right after reset.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("Stalled result transaction changed.");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("Input accepted while results are pending.");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("Input still accepted after the final element of a set.");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("Result offered after the end of a run.");

endmodule

bind heap_sort_engine_top hse_checker u_hse_checker (.*);

`default_nettype wire

// ===== tb/tb_heap_sort_engine_top.sv =====
// Self-checking testbench for heap_sort_engine_top: it streams sets of signed values and
// checks that each set returns in ascending order with the right end and overflow flags.
// Depends on hse_pkg and the RTL of the block only.
module tb_heap_sort_engine_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_W                = hse_pkg::HSE_DATA_W;
   localparam int CAPACITY              = hse_pkg::HSE_CAPACITY;
   localparam int QUIET_LIMIT           = 20000;
   localparam int HOLD_CYCLES           = 400;
   localparam int TAIL_CYCLES           = 64;
   localparam int SMALL_ITEMS_PER_PHASE = 45;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     end_of_run;
      logic                     overflow;
   } sorted_word_type;

   class sort_scoreboard;
      logic signed [DATA_W-1:0] loaded[$];
      bit                       dropped;
      sorted_word_type          awaited[$];
      int                       errors;
      int                       results;
      int                       sets;
      int                       overflow_sets;

      task report_mismatch(input string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         errors++;
      endtask

      function void note_element(input logic signed [DATA_W-1:0] value, input logic is_last);
         logic signed [DATA_W-1:0] ascending[$];
         sorted_word_type          word;
         int                       pos;
         if (loaded.size() < CAPACITY) begin
            loaded.push_back(value);
         end else begin
            dropped = 1'b1;
         end
         if (!is_last) return;
         foreach (loaded[i]) begin
            pos = 0;
            while (pos < ascending.size() && ascending[pos] <= loaded[i]) pos++;
            ascending.insert(pos, loaded[i]);
         end
         foreach (ascending[i]) begin
            word.value      = ascending[i];
            word.end_of_run = (i == ascending.size() - 1);
            word.overflow   = dropped;
            awaited.push_back(word);
         end
         sets++;
         if (dropped) overflow_sets++;
         loaded.delete();
         dropped = 1'b0;
      endfunction

      task check_result(input logic [DATA_W-1:0] data, input logic tlast, input logic tuser);
         sorted_word_type want;
         results++;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected",
                                      $signed(data)));
            return;
         end
         want = awaited.pop_front();
         if (data !== want.value)
            report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                      $signed(data), want.value));
         if (tlast !== want.end_of_run)
            report_mismatch($sformatf("end_of_run %b, expected %b", tlast, want.end_of_run));
         if (tuser !== want.overflow)
            report_mismatch($sformatf("overflow %b, expected %b", tuser, want.overflow));
      endtask
   endclass

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic              rsp_tlast;
   logic              rsp_tuser;

   sort_scoreboard    board;
   int                idle_pct     = 0;
   int                stall_pct    = 0;
   int                holds_asked  = 0;
   int                holds_given  = 0;
   int                hold_left    = 0;
   int                quiet_cycles = 0;
   int                items_sent   = 0;
   logic [DATA_W-1:0] recent_value = '0;
   logic [DATA_W-1:0] directed_values[$];

   heap_sort_engine_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (holds_asked > holds_given && rsp_tvalid) begin
            holds_given++;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [DATA_W-1:0] random_value();
      logic [DATA_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: v = $urandom;
         6, 7:             v = $urandom_range(0, 8) - 4;
         8:                v = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         default:          v = recent_value;
      endcase
      recent_value = v;
      return v;
   endfunction

   task automatic send_element(input logic [DATA_W-1:0] value, input logic is_last);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      board.note_element(value, is_last);
      items_sent++;
   endtask

   task automatic send_directed_set();
      foreach (directed_values[i])
         send_element(directed_values[i], i == directed_values.size() - 1);
   endtask

   task automatic send_random_set(input int set_len);
      for (int i = 0; i < set_len; i++) send_element(random_value(), i == set_len - 1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.awaited.size() != 0);
   endtask

   initial begin
      int set_len;
      int phase_items;
      bit paused;
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      directed_values = '{32'h8000_0000};
      send_directed_set();
      directed_values = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
                          32'h0000_0001};
      send_directed_set();
      directed_values = '{32'd5, 32'd5, 32'hffff_fffd, 32'd5, 32'hffff_fffd};
      send_directed_set();
      directed_values = '{32'h7fff_ffff, 32'h7fff_ffff};
      send_directed_set();
      directed_values = '{32'd8, 32'd7, 32'd6, 32'd5, 32'd4, 32'd3, 32'h5555_5555,
                          32'haaaa_aaaa};
      send_directed_set();
      wait_drained();

      paused = 1'b0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 72; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 72; end
            default: begin idle_pct = 28; stall_pct = 28; end
         endcase
         phase_items = 0;
         while (phase_items < SMALL_ITEMS_PER_PHASE) begin
            set_len = $urandom_range(1, 10);
            if (set_len > SMALL_ITEMS_PER_PHASE - phase_items)
               set_len = SMALL_ITEMS_PER_PHASE - phase_items;
            if (phase == 0 && phase_items == 0) holds_asked++;
            if (phase == 2 && !paused && phase_items >= SMALL_ITEMS_PER_PHASE / 2) begin
               wait_drained();
               paused = 1'b1;
            end
            send_random_set(set_len);
            phase_items += set_len;
         end
         if (phase == 1) send_random_set(CAPACITY);
         if (phase == 3) send_random_set(CAPACITY + $urandom_range(1, 6));
         wait_drained();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.awaited.size() != 0)
         board.report_mismatch($sformatf("%0d results never arrived", board.awaited.size()));
      $display("Sorted %0d sets from %0d transactions, %0d of them past capacity; %0d results.",
               board.sets, items_sent, board.overflow_sets, board.results);
      $display("Ran with no idling, sender gaps, receiver stalls, both, and one long hold.");
      if (board.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
